/* rtl/bpe_pkg.sv */
// Shared types, constants and a helper function of the breakpoint envelope generator.
package bpe_pkg;

    // Breakpoint table.
    localparam int POINTS = 8;
    localparam int PT_W   = 16;
    localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;

    // Configuration port.
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_HIGH = 2'd3;

    // Rate register, units of 2^-20 s.
    localparam int RATE_W = 27;
    localparam logic [RATE_W-1:0] RATE_MIN   = 27'd1049;
    localparam logic [RATE_W-1:0] RATE_RESET = 27'd1048576;

    // Phase in Q1.24: the one integer bit lets it hold exactly 1.0.
    localparam int PHASE_FRAC = 24;
    localparam int PHASE_W    = PHASE_FRAC + 1;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC;

    // Increment division: |dt| * 2^24 / rate.
    localparam int DT_W       = 22;
    localparam int DIVIDEND_W = DT_W + PHASE_FRAC;
    // Largest quotient is 2^45 / 1049, which needs 35 bits.
    localparam int QUOT_W     = 36;
    localparam int SUM_W      = QUOT_W + 2;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // Segment position: phase times the segment count.
    localparam int SEG_X_W = PHASE_FRAC + IDX_W;
    localparam int DIFF_W  = PT_W + 1;
    localparam int PROD_W  = DIFF_W + PHASE_FRAC + 1;

    typedef enum logic [0:0] {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ACCUM,
        ST_SEGMENT,
        ST_MULTIPLY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic div_step;
        logic accum;
        logic segment;
        logic multiply;
        logic out_load;
    } cmd_t;

    // Breakpoint k out of the two packed point registers.
    function automatic logic signed [PT_W-1:0] point_at(
        input logic [CFG_W-1:0] low,
        input logic [CFG_W-1:0] high,
        input logic [IDX_W-1:0] k
    );
        logic [2*CFG_W-1:0] all_points;
        all_points = {high, low};
        return all_points[PT_W*k +: PT_W];
    endfunction

endpackage

/* rtl/bpe_ctrl.sv */
// Controller state machine of the breakpoint envelope generator.
module bpe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    output logic              m_valid,
    input  logic              m_ready,
    output bpe_pkg::cmd_t     cmd
);

    bpe_pkg::state_t state_reg, state_next;
    logic [bpe_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic m_valid_reg, m_valid_next;
    logic div_last;
    logic out_free;

    assign div_last = (div_cnt_reg == bpe_pkg::DIV_CNT_W'(bpe_pkg::DIVIDEND_W - 1));
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpe_pkg::ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpe_pkg::ST_IDLE: begin
                if (s_valid && s_operation == bpe_pkg::OP_TICK) begin
                    state_next = bpe_pkg::ST_DIVIDE;
                end
            end
            bpe_pkg::ST_DIVIDE: begin
                if (div_last) begin
                    state_next = bpe_pkg::ST_ACCUM;
                end
            end
            bpe_pkg::ST_ACCUM:    state_next = bpe_pkg::ST_SEGMENT;
            bpe_pkg::ST_SEGMENT:  state_next = bpe_pkg::ST_MULTIPLY;
            bpe_pkg::ST_MULTIPLY: state_next = bpe_pkg::ST_FINISH;
            bpe_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = bpe_pkg::ST_IDLE;
                end
            end
            default: state_next = bpe_pkg::ST_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            bpe_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                div_cnt_next = '0;
                if (s_valid) begin
                    cmd.restart = (s_operation == bpe_pkg::OP_RESTART);
                    cmd.load    = (s_operation == bpe_pkg::OP_TICK);
                end
            end
            bpe_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            bpe_pkg::ST_ACCUM:    cmd.accum    = 1'b1;
            bpe_pkg::ST_SEGMENT:  cmd.segment  = 1'b1;
            bpe_pkg::ST_MULTIPLY: cmd.multiply = 1'b1;
            bpe_pkg::ST_FINISH:   cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/bpe_datapath.sv */
// Datapath: configuration registers, serial divider, phase accumulator and interpolator.
module bpe_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bpe_pkg::cmd_t                         cmd,
    input  logic signed [bpe_pkg::DT_W-1:0]       s_dt,
    input  logic                                  cfg_wr_en,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]             cfg_wdata,
    output logic signed [bpe_pkg::PT_W-1:0]       m_value
);

    // Configuration registers.
    logic [bpe_pkg::RATE_W-1:0] rate_reg;
    logic                       loop_mode_reg;
    logic [bpe_pkg::CFG_W-1:0]  points_low_reg;
    logic [bpe_pkg::CFG_W-1:0]  points_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg        <= bpe_pkg::RATE_RESET;
            loop_mode_reg   <= 1'b0;
            points_low_reg  <= '0;
            points_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bpe_pkg::CFG_RATE:        rate_reg        <= cfg_wdata[bpe_pkg::RATE_W-1:0];
                bpe_pkg::CFG_LOOP_MODE:   loop_mode_reg   <= cfg_wdata[0];
                bpe_pkg::CFG_POINTS_LOW:  points_low_reg  <= cfg_wdata;
                bpe_pkg::CFG_POINTS_HIGH: points_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [bpe_pkg::RATE_W-1:0]     divisor_reg;
    logic [bpe_pkg::RATE_W-1:0]     rem_reg, rem_next;
    logic [bpe_pkg::DIVIDEND_W-1:0] quot_reg, quot_next;
    logic                           neg_reg;
    logic [bpe_pkg::DT_W-1:0]       dt_mag;
    logic [bpe_pkg::RATE_W:0]       rem_shift;
    logic [bpe_pkg::RATE_W:0]       rem_trial;
    logic                           quot_bit;

    assign dt_mag    = s_dt[bpe_pkg::DT_W-1] ? bpe_pkg::DT_W'(-s_dt) : bpe_pkg::DT_W'(s_dt);
    assign rem_shift = {rem_reg, quot_reg[bpe_pkg::DIVIDEND_W-1]};
    assign rem_trial = rem_shift - {1'b0, divisor_reg};
    assign quot_bit  = !rem_trial[bpe_pkg::RATE_W];

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (cmd.load) begin
            rem_next  = '0;
            quot_next = {dt_mag, bpe_pkg::PHASE_FRAC'(0)};
        end else if (cmd.div_step) begin
            rem_next  = quot_bit ? rem_trial[bpe_pkg::RATE_W-1:0]
                                 : rem_shift[bpe_pkg::RATE_W-1:0];
            quot_next = {quot_reg[bpe_pkg::DIVIDEND_W-2:0], quot_bit};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (cmd.load) begin
            divisor_reg <= (rate_reg < bpe_pkg::RATE_MIN) ? bpe_pkg::RATE_MIN : rate_reg;
            neg_reg     <= s_dt[bpe_pkg::DT_W-1];
        end
    end

    // Phase accumulation with wrap, clamp and one-shot hold.
    logic [bpe_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic                             hold_last_reg;
    logic [bpe_pkg::SUM_W-1:0]        inc_abs;
    logic signed [bpe_pkg::SUM_W-1:0] inc;
    logic signed [bpe_pkg::SUM_W-1:0] sum;
    logic                             sum_neg;
    logic                             sum_over;

    assign inc_abs  = bpe_pkg::SUM_W'(quot_reg[bpe_pkg::QUOT_W-1:0]);
    assign inc      = neg_reg ? $signed(-inc_abs) : $signed(inc_abs);
    assign sum      = $signed(bpe_pkg::SUM_W'(phase_reg)) + inc;
    assign sum_neg  = sum[bpe_pkg::SUM_W-1];
    assign sum_over = !sum_neg && (sum >= $signed(bpe_pkg::SUM_W'(bpe_pkg::PHASE_ONE)));

    always_comb begin
        phase_next = phase_reg;
        if (cmd.restart) begin
            phase_next = '0;
        end else if (cmd.accum) begin
            priority if (sum_neg) begin
                phase_next = '0;
            end else if (loop_mode_reg) begin
                phase_next = {1'b0, sum[bpe_pkg::PHASE_FRAC-1:0]};
            end else if (sum_over) begin
                phase_next = bpe_pkg::PHASE_ONE;
            end else begin
                phase_next = sum[bpe_pkg::PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
        if (cmd.accum) begin
            hold_last_reg <= !loop_mode_reg && sum_over;
        end
    end

    // Segment selection.
    logic [bpe_pkg::SEG_X_W-1:0]        seg_x;
    logic [bpe_pkg::IDX_W-1:0]          seg_i;
    logic [bpe_pkg::IDX_W-1:0]          seg_nxt;
    logic [bpe_pkg::PHASE_FRAC-1:0]     seg_f;
    logic signed [bpe_pkg::PT_W-1:0]    pt_a, pt_b, pt_last;
    logic signed [bpe_pkg::PT_W-1:0]    seg_a_reg;
    logic signed [bpe_pkg::DIFF_W-1:0]  seg_diff_reg;
    logic [bpe_pkg::PHASE_FRAC-1:0]     seg_f_reg;

    always_comb begin
        if (loop_mode_reg) begin
            seg_x = bpe_pkg::SEG_X_W'(bpe_pkg::SEG_X_W'(phase_reg[bpe_pkg::PHASE_FRAC-1:0])
                    * bpe_pkg::SEG_X_W'(bpe_pkg::POINTS));
        end else begin
            seg_x = bpe_pkg::SEG_X_W'(bpe_pkg::SEG_X_W'(phase_reg[bpe_pkg::PHASE_FRAC-1:0])
                    * bpe_pkg::SEG_X_W'(bpe_pkg::POINTS - 1));
        end
        seg_i = seg_x[bpe_pkg::SEG_X_W-1:bpe_pkg::PHASE_FRAC];
        seg_f = seg_x[bpe_pkg::PHASE_FRAC-1:0];
        // In loop mode the last point joins back to the first.
        if (loop_mode_reg && seg_i == bpe_pkg::IDX_W'(bpe_pkg::POINTS - 1)) begin
            seg_nxt = '0;
        end else begin
            seg_nxt = seg_i + 1'b1;
        end
        pt_a    = bpe_pkg::point_at(points_low_reg, points_high_reg, seg_i);
        pt_b    = bpe_pkg::point_at(points_low_reg, points_high_reg, seg_nxt);
        pt_last = bpe_pkg::point_at(points_low_reg, points_high_reg,
                                    bpe_pkg::IDX_W'(bpe_pkg::POINTS - 1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.segment) begin
            if (hold_last_reg) begin
                seg_a_reg    <= pt_last;
                seg_diff_reg <= '0;
                seg_f_reg    <= '0;
            end else begin
                seg_a_reg    <= pt_a;
                seg_diff_reg <= bpe_pkg::DIFF_W'(pt_b) - bpe_pkg::DIFF_W'(pt_a);
                seg_f_reg    <= seg_f;
            end
        end
    end

    // Interpolation product and rounding.
    logic signed [bpe_pkg::PROD_W-1:0] prod_reg;
    logic signed [bpe_pkg::PROD_W-1:0] prod_round;
    logic signed [bpe_pkg::DIFF_W-1:0] delta;
    logic signed [bpe_pkg::DIFF_W:0]   value_wide;
    logic signed [bpe_pkg::PT_W-1:0]   value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.multiply) begin
            prod_reg <= bpe_pkg::PROD_W'(seg_diff_reg * $signed({1'b0, seg_f_reg}));
        end
        if (cmd.out_load) begin
            value_reg <= value_wide[bpe_pkg::PT_W-1:0];
        end
    end

    // Adding one half and shifting right rounds half toward plus infinity.
    assign prod_round = prod_reg + bpe_pkg::PROD_W'(1 << (bpe_pkg::PHASE_FRAC - 1));
    assign delta      = prod_round[bpe_pkg::PHASE_FRAC +: bpe_pkg::DIFF_W];
    assign value_wide = (bpe_pkg::DIFF_W + 1)'(seg_a_reg) + (bpe_pkg::DIFF_W + 1)'(delta);
    assign m_value    = value_reg;

endmodule

/* rtl/breakpoint_envelope_generator.sv */
// Top level of the eight-point piecewise-linear envelope and LFO generator.
//
// Input channel (s_valid, s_ready, s_operation, s_dt): each request is a tick, which
// advances the phase by dt/rate and produces one envelope value, or a restart, which
// clears the phase and produces nothing. Result channel (m_valid, m_ready, m_value):
// one signed Q1.15 value per tick. Configuration: cfg_wr_en writes cfg_wdata into the
// register selected by cfg_index (rate, loop_mode, points_low, points_high) at that
// clock edge; write only while no tick is in flight.
//
// Sequence: a tick runs from acceptance to m_valid through the bit-serial divider that
// forms dt * 2^24 / rate (one quotient bit per cycle), then through the phase update,
// segment selection, the interpolation multiply and the final rounding add into the
// output register. The next request is accepted in the cycle after the result is
// loaded, so a tick does not overlap the next one; a restart leaves the controller idle.
//
// The result sits in an output register, so the next request is accepted while it
// waits; if the receiver stalls, the following tick holds in its last step until the
// output register is free. Reset (aresetn low, synchronous) returns the controller to
// idle, drops m_valid, clears the phase and restores rate 1048576, one-shot mode and
// all points zero.
module breakpoint_envelope_generator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic signed [bpe_pkg::DT_W-1:0]      s_dt,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bpe_pkg::PT_W-1:0]      m_value,
    input  logic                                 cfg_wr_en,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]            cfg_wdata
);

    bpe_pkg::cmd_t cmd;

    // Sequencing of each request through divider, accumulator and interpolator.
    bpe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    // Arithmetic, phase state and configuration registers.
    bpe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_dt      (s_dt),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_value   (m_value)
    );

endmodule
